// ----- hw/rtl/cobs_frame_encoder_defines.svh -----
// Assertion macros used by the checker file of the COBS encoder.
`ifndef COBS_FRAME_ENCODER_DEFINES_SVH
`define COBS_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define CFE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cobs encoder check failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define CFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cobs encoder check failed");

`endif

// ----- hw/rtl/cfe_pkg.sv -----
package cfe_pkg;

    // Largest number of bytes held in one group.
    localparam int GROUP_MAX = 32;
    // Width of the held byte count, which must reach GROUP_MAX itself.
    localparam int COUNT_W = 6;
    // Width of a group store address.
    localparam int ADDR_W = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;

    localparam logic [7:0] DELIMITER = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } cfe_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
        logic       dropped;
    } cfe_out_t;

endpackage

// ----- hw/rtl/cobs_frame_encoder.sv -----
// COBS frame encoder: one message byte in per item, encoded bytes out per item.
// A held byte is only stored. A byte that closes a group sends the group code, the held
// bytes, for a last zero (store not full) an empty final group, for a last byte the
// delimiter; input stalls meanwhile. With no receiver stall, one output byte per cycle,
// set by the output register and the store's read port.
// Reset (rst_n, asynchronous, active low) clears count, flags and state; no clearing pass.
module cobs_frame_encoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  cfe_pkg::cfe_in_t byte_item,
    output logic             code_valid,
    input  logic             code_stall,
    output cfe_pkg::cfe_out_t code_item
);

    // Sequencer states. IDLE takes message bytes; CODE sends the group code;
    // DATA sends the held bytes from the store; DELIM sends the frame delimiter.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CODE  = 2'd1;
    localparam logic [1:0] S_DATA  = 2'd2;
    localparam logic [1:0] S_DELIM = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [cfe_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                         drop_reg, drop_next;
    // A trailing empty group is still owed after the current one.
    logic                         extra_reg, extra_next;
    // The frame delimiter is still owed after the groups.
    logic                         delim_reg, delim_next;
    logic [cfe_pkg::ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;

    cfe_pkg::cfe_out_t            out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    // Group store: a synchronous memory with a registered read port.
    logic [7:0]                   mem [cfe_pkg::GROUP_MAX];
    logic [7:0]                   q_reg;
    logic                         wr_en;
    logic [cfe_pkg::ADDR_W-1:0]   wr_addr;

    logic accept;
    logic slot_free;
    logic full;

    assign byte_stall = (state_reg != S_IDLE);
    assign accept     = byte_valid && !byte_stall;
    // The output register can take a new byte when empty or being emptied now.
    assign slot_free  = !out_valid_reg || !code_stall;
    assign full       = (count_reg >= cfe_pkg::COUNT_W'(cfe_pkg::GROUP_MAX));
    assign wr_addr    = cfe_pkg::ADDR_W'(count_reg);

    assign code_valid = out_valid_reg;
    assign code_item  = out_reg;

    // The store is read every cycle at the next pointer, so q_reg always holds
    // the entry at rd_ptr_reg. A write to the same entry in the same cycle is
    // forwarded, which covers a closing byte written just before its group is read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= byte_item.data_byte;
        end
        if (wr_en && (wr_addr == rd_ptr_next))
        begin
            q_reg <= byte_item.data_byte;
        end
        else
        begin
            q_reg <= mem[rd_ptr_next];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        extra_next     = extra_reg;
        delim_next     = delim_reg;
        rd_ptr_next    = rd_ptr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && code_stall;
        wr_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                rd_ptr_next = '0;
                if (accept)
                begin
                    if (byte_item.data_byte != cfe_pkg::DELIMITER)
                    begin
                        // Non-zero byte: hold it, or drop it when the store is full.
                        if (!full)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                        if (byte_item.last_byte)
                        begin
                            extra_next = 1'b0;
                            delim_next = 1'b1;
                            state_next = S_CODE;
                        end
                    end
                    else
                    begin
                        // Zero byte closes the group. As the last byte it also owes an
                        // empty final group, unless the store is full, in which case
                        // that zero is dropped.
                        if (byte_item.last_byte && full)
                        begin
                            drop_next = 1'b1;
                        end
                        extra_next = byte_item.last_byte && !full;
                        delim_next = byte_item.last_byte;
                        state_next = S_CODE;
                    end
                end
            end

            S_CODE:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.out_byte   = 8'(count_reg) + 8'd1;
                    out_next.frame_end  = 1'b0;
                    out_next.dropped    = drop_reg;
                    out_next.last_of_run = 1'b0;
                    rd_ptr_next         = '0;
                    if (count_reg == '0)
                    begin
                        // Empty group: the code is the whole group.
                        out_next.last_of_run = !extra_reg && !delim_reg;
                        if (extra_reg)
                        begin
                            extra_next = 1'b0;
                            state_next = S_CODE;
                        end
                        else if (delim_reg)
                        begin
                            state_next = S_DELIM;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_DATA;
                    end
                end
            end

            S_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.out_byte    = q_reg;
                    out_next.frame_end   = 1'b0;
                    out_next.dropped     = drop_reg;
                    out_next.last_of_run = 1'b0;
                    if (cfe_pkg::COUNT_W'(rd_ptr_reg) == (count_reg - 1'b1))
                    begin
                        // Final held byte: the group is done and the store is empty.
                        rd_ptr_next          = '0;
                        count_next           = '0;
                        out_next.last_of_run = !extra_reg && !delim_reg;
                        if (extra_reg)
                        begin
                            extra_next = 1'b0;
                            state_next = S_CODE;
                        end
                        else if (delim_reg)
                        begin
                            state_next = S_DELIM;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end
            end

            S_DELIM:
            begin
                if (slot_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.out_byte    = cfe_pkg::DELIMITER;
                    out_next.frame_end   = 1'b1;
                    out_next.dropped     = drop_reg;
                    out_next.last_of_run = 1'b1;
                    // The frame is closed: the drop report and the group start afresh.
                    count_next           = '0;
                    drop_next            = 1'b0;
                    delim_next           = 1'b0;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            extra_reg     <= 1'b0;
            delim_reg     <= 1'b0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            extra_reg     <= extra_next;
            delim_reg     <= delim_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ----- hw/rtl/cfe_checker.sv -----
`include "cobs_frame_encoder_defines.svh"

module cfe_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              byte_valid,
    input logic              byte_stall,
    input cfe_pkg::cfe_in_t  byte_item,
    input logic              code_valid,
    input logic              code_stall,
    input cfe_pkg::cfe_out_t code_item
);

    // A delimiter is a zero byte and always ends its run.
    `CFE_ASSERT_NOW(a_delim_form, code_valid && code_item.frame_end, code_item.out_byte == cfe_pkg::DELIMITER && code_item.last_of_run)

    // Codes and held bytes are never zero, so a zero byte is always the delimiter.
    `CFE_ASSERT_NOW(a_zero_is_delim, code_valid && code_item.out_byte == cfe_pkg::DELIMITER, code_item.frame_end)

    // A closing byte starts the output run, so the input side stalls next cycle.
    `CFE_ASSERT_NEXT(a_close_stalls, byte_valid && !byte_stall && byte_item.last_byte, byte_stall)

    // A held non-zero byte causes no output run, so input stays open.
    `CFE_ASSERT_NEXT(a_hold_open, byte_valid && !byte_stall && !byte_item.last_byte && byte_item.data_byte != cfe_pkg::DELIMITER, !byte_stall)

    // A stalled item holds.
    `CFE_ASSERT_NEXT(a_out_hold, code_valid && code_stall, code_valid && $stable(code_item))

endmodule

bind cobs_frame_encoder cfe_checker u_cfe_checker (.*);

// ----- verif/tb_cobs_frame_encoder.sv -----
module tb_cobs_frame_encoder;

    // The run stops here whatever happens.
    localparam int CYCLE_LIMIT   = 200000;
    // Length of the long receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES   = 300;
    // Items offered after the directed part, including the long group runs.
    localparam int RANDOM_ITEMS  = 260;
    // Quiet cycles after the last expected byte, to catch anything spurious.
    localparam int SETTLE_CYCLES = 40;

    // How a long run of non-zero bytes is finished off.
    typedef enum int {
        END_ZERO,
        END_BYTE,
        END_CONTINUE
    } run_end_e;

    // The scoreboard keeps its own copy of the encoder state. Each accepted
    // message byte is encoded into the bytes the block must produce, and each
    // produced byte is compared with the oldest of those still waiting.
    class cobs_scoreboard;
        logic [7:0]           held_bytes [cfe_pkg::GROUP_MAX];
        int unsigned          held_count;
        bit                   drop_seen;
        cfe_pkg::cfe_out_t    expected_codes [$];
        int                   errors;

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        function void queue_code(logic [7:0] value, logic closing);
            cfe_pkg::cfe_out_t code;
            code.out_byte    = value;
            code.last_of_run = 1'b0;
            code.frame_end   = closing;
            code.dropped     = drop_seen;
            expected_codes.push_back(code);
        endfunction

        function void mark_last_of_run();
            cfe_pkg::cfe_out_t code;
            code = expected_codes.pop_back();
            code.last_of_run = 1'b1;
            expected_codes.push_back(code);
        endfunction

        function void close_group();
            queue_code(8'(held_count + 1), 1'b0);
            for (int i = 0; i < held_count; i++)
                queue_code(held_bytes[i], 1'b0);
            held_count = 0;
        endfunction

        function void close_frame();
            queue_code(cfe_pkg::DELIMITER, 1'b1);
            mark_last_of_run();
            held_count = 0;
            drop_seen  = 1'b0;
        endfunction

        // Encodes one accepted message byte.
        function void take_byte(cfe_pkg::cfe_in_t item);
            bit full;
            full = held_count >= cfe_pkg::GROUP_MAX;
            if (item.data_byte != 8'h00) begin
                if (!full) begin
                    held_bytes[held_count] = item.data_byte;
                    held_count++;
                end
                else
                    drop_seen = 1'b1;
                if (item.last_byte) begin
                    close_group();
                    close_frame();
                end
            end
            else begin
                // A closing zero on a full group is dropped rather than
                // opening an empty trailing group.
                if (item.last_byte && full)
                    drop_seen = 1'b1;
                close_group();
                if (!item.last_byte)
                    mark_last_of_run();
                else begin
                    if (!full)
                        close_group();
                    close_frame();
                end
            end
        endfunction

        task check_code(cfe_pkg::cfe_out_t got);
            cfe_pkg::cfe_out_t want;
            if (expected_codes.size() == 0) begin
                report_mismatch($sformatf("byte %02h produced with nothing expected",
                                          got.out_byte));
                return;
            end
            want = expected_codes.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          got.out_byte, want.out_byte));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                          got.last_of_run, want.last_of_run, want.out_byte));
            if (got.frame_end !== want.frame_end)
                report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
                                          got.frame_end, want.frame_end, want.out_byte));
            if (got.dropped !== want.dropped)
                report_mismatch($sformatf("dropped %b, expected %b on byte %02h",
                                          got.dropped, want.dropped, want.out_byte));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              byte_valid;
    logic              byte_stall;
    cfe_pkg::cfe_in_t  byte_item;
    logic              code_valid;
    logic              code_stall;
    cfe_pkg::cfe_out_t code_item;

    cobs_scoreboard sb = new;

    // When calm is set, neither side idles, so the block runs at its full rate.
    logic calm;
    // The stimulus raises hold_go once; the hold-off process then keeps the
    // receiver stalled for HOLD_CYCLES while items keep being offered.
    logic hold_go;
    logic hold_off;
    int   bytes_sent;

    cobs_frame_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_item  (code_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one message byte after a random gap and returns at the clock edge
    // at which it was taken. The valid is only lowered when a gap follows, so
    // back-to-back items keep it high without a glitch.
    task automatic send_byte(input logic [7:0] value, input logic closing);
        cfe_pkg::cfe_in_t item;
        int               gap;
        item.data_byte = value;
        item.last_byte = closing;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= item;
        do @(posedge clk); while (byte_stall);
        sb.take_byte(item);
        bytes_sent++;
    endtask

    function automatic logic [7:0] any_nonzero();
        return 8'($urandom_range(1, 255));
    endfunction

    // A short message with roughly one zero byte in four.
    task automatic send_short_frame();
        int len;
        len = $urandom_range(1, 10);
        for (int i = 1; i <= len; i++)
            send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : any_nonzero(), i == len);
    endtask

    // A long run of non-zero bytes, which fills the group store when it is
    // long enough, followed by the chosen kind of ending.
    task automatic send_run_frame(input int run_len, input run_end_e ending);
        for (int i = 0; i < run_len; i++)
            send_byte(any_nonzero(), 1'b0);
        case (ending)
            END_ZERO: send_byte(8'h00, 1'b1);
            END_BYTE: send_byte(any_nonzero(), 1'b1);
            default:
            begin
                send_byte(8'h00, 1'b0);
                send_byte(any_nonzero(), 1'b1);
            end
        endcase
    endtask

    // Receiver: takes a result whenever one is offered and not stalled, then
    // draws a fresh pause for the next one. The long hold-off overrides it.
    initial
    begin : receiver
        int pause_left;
        pause_left = 0;
        code_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && code_valid && !code_stall)
            begin
                sb.check_code(code_item);
                pause_left = calm ? 0 : $urandom_range(0, 5);
            end
            else if (pause_left > 0)
                pause_left--;
            code_stall <= hold_off || (pause_left > 0);
        end
    end

    // The long hold-off is counted here, apart from the stimulus, so that the
    // sender carries on offering items until the block pushes back.
    initial
    begin : receiver_hold
        hold_off <= 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int random_start;
        int choice;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        calm       <= 1'b0;
        hold_go    <= 1'b0;
        bytes_sent  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Single-byte messages at both ends of the byte range,
        // an empty message (a lone closing zero), a zero that opens a message,
        // consecutive zeros giving empty groups, and closing zeros after held
        // bytes, which add the trailing empty group before the delimiter.
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);

        // Random part. It opens with the group store cases: a group one short
        // of full closed by a zero (the longest burst of results), a full group
        // closed by a zero (the zero is dropped), a full group closed by a byte
        // (that byte is dropped), a group exactly full, and an overfull run
        // whose drop report must stay set into the group that follows.
        random_start = bytes_sent;
        send_run_frame(cfe_pkg::GROUP_MAX - 1, END_ZERO);
        hold_go <= 1'b1;
        send_run_frame(cfe_pkg::GROUP_MAX, END_ZERO);
        send_run_frame(cfe_pkg::GROUP_MAX, END_BYTE);
        send_run_frame(cfe_pkg::GROUP_MAX - 1, END_BYTE);
        send_run_frame(cfe_pkg::GROUP_MAX + 3, END_CONTINUE);

        // Mostly short well-formed messages with random content, some long
        // runs, and a little noise: single bytes with a random closing mark.
        while (bytes_sent - random_start < RANDOM_ITEMS)
        begin
            calm <= (bytes_sent - random_start >= 180) && (bytes_sent - random_start < 230);
            choice = $urandom_range(0, 99);
            if (choice < 82)
                send_short_frame();
            else if (choice < 90)
                send_run_frame($urandom_range(cfe_pkg::GROUP_MAX - 4, cfe_pkg::GROUP_MAX + 4),
                               run_end_e'($urandom_range(0, 2)));
            else
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        // Close whatever message is still open so that its bytes come out.
        send_byte(8'h00, 1'b1);
        byte_valid <= 1'b0;

        while (sb.expected_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.expected_codes.size() != 0)
            sb.report_mismatch("expected bytes never arrived");

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- cobs_frame_encoder.f -----
+incdir+hw/rtl
hw/rtl/cfe_pkg.sv
hw/rtl/cobs_frame_encoder.sv
hw/rtl/cfe_checker.sv
verif/tb_cobs_frame_encoder.sv
